### src/crtb_pkg.sv
// Shared types and constants for the command retry table with backoff.
// Used by the interfaces, the slot cell and the top level.
package crtb_pkg;

  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned ResCntW       = $clog2(MaxResults + 1);
  localparam int unsigned ResIdxW       = $clog2(MaxResults);
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [3:0] MaxRetriesRst     = 4'd5;
  localparam logic [7:0] HbLimitRst        = 8'd3;
  localparam logic [7:0] HbAgeMax          = 8'd255;

  // request types
  localparam logic [2:0] ReqTrack      = 3'd0;
  localparam logic [2:0] ReqAck        = 3'd1;
  localparam logic [2:0] ReqTick       = 3'd2;
  localparam logic [2:0] ReqHeartbeat  = 3'd3;
  localparam logic [2:0] ReqFlush      = 3'd4;
  localparam logic [2:0] ReqDisconnect = 3'd5;

  // result events
  localparam logic [2:0] EvAcked      = 3'd0;
  localparam logic [2:0] EvAckUnknown = 3'd1;
  localparam logic [2:0] EvTracked    = 3'd2;
  localparam logic [2:0] EvFull       = 3'd3;
  localparam logic [2:0] EvResend     = 3'd4;
  localparam logic [2:0] EvDropped    = 3'd5;
  localparam logic [2:0] EvStatus     = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxRetries = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHbLimit    = 2'd1;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [15:0] kind;
    logic [3:0]  retries;
    logic [31:0] sent;
  } slot_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] id;
    logic [15:0] kind;
    logic [3:0]  att;
  } event_t;

endpackage

### src/crtb_ifs.sv
// Handshake interfaces for request, result and configuration channels.
// Depends on crtb_pkg.
interface crtb_req_if import crtb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] cmd_id;
  logic [15:0] msg_kind;
  modport source (output valid, req_type, cmd_id, msg_kind, input ready);
  modport sink (input valid, req_type, cmd_id, msg_kind, output ready);
endinterface

interface crtb_res_if import crtb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] out_cmd_id;
  logic [15:0] out_kind;
  logic [3:0]  attempt;
  logic        healthy;
  logic        link_is_up;
  logic        last;
  modport source (output valid, event_res, out_cmd_id, out_kind, attempt, healthy,
                  link_is_up, last, input ready);
  modport sink (input valid, event_res, out_cmd_id, out_kind, attempt, healthy,
                link_is_up, last, output ready);
endinterface

interface crtb_cfg_if import crtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/crtb_cell.sv
// One table slot of the rotating slot chain.
// Depends on crtb_pkg for the slot layout.
module crtb_cell import crtb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t shift_in_i,
  input  logic  wr_en_i,
  input  slot_t wr_data_i,
  output slot_t slot_o
);

  slot_t slot_q;
  logic  valid_q;

  // hold valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= wr_data_i.valid;
    end else if (shift_i) begin
      valid_q <= shift_in_i.valid;
    end
  end

  // take a direct write or the neighbor's slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q <= wr_data_i;
    end else if (shift_i) begin
      slot_q <= shift_in_i;
    end
  end

  always_comb begin
    slot_o       = slot_q;
    slot_o.valid = valid_q;
  end

endmodule

### src/command_retry_table_backoff_unit.sv
// Top level of the command retry table with exponential backoff.
// Depends on crtb_pkg, the channel interfaces and crtb_cell.
//
// Usage: requests arrive on req_i (track, ack, one-second tick, heartbeat,
// flush, disconnect); results leave on res_o; cfg_i writes the retry limit
// (index 0) and heartbeat_limit (index 1) and is always ready.
// The slots sit in a ring of cells that rotates one slot per cycle past a
// single update unit at the head. Track, ack, tick and flush make one full
// rotation of TABLE_DEPTH slots, then close out in the finish state;
// heartbeat, disconnect and other codes go straight to the finish state.
// Results are queued (up to 16) and then shown one per cycle while the
// receiver takes them, on a registered output, with healthy and link_is_up
// taken after the whole request, and last on the final one.
// A new request is taken once the last result is loaded into the output
// register, even while that result still waits.
// Reset empties the table, zeroes time, saturates heartbeat age (unhealthy),
// raises the link and loads the register defaults. A stalled receiver holds
// the output register and the queue drain pauses.
module command_retry_table_backoff_unit import crtb_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  crtb_req_if.sink   req_i,
  crtb_res_if.source res_o,
  crtb_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {StIdle, StScan, StFin, StEmit} state_e;

  state_e      state_q;
  logic [3:0]  retry_limit_q;
  logic [7:0]  hb_limit_q;
  logic [31:0] now_q;
  logic [7:0]  hb_age_q;
  logic        link_q;
  logic [2:0]  req_q;
  logic [31:0] id_q;
  logic [15:0] kind_q;
  logic [IdxW-1:0] k_q;
  logic        hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [ResCntW-1:0] cnt_q;
  logic [ResIdxW-1:0] rd_q;
  event_t      evq_q [MaxResults];

  logic        res_valid_q;
  event_t      res_ev_q;
  logic        res_healthy_q, res_link_q, res_last_q;

  slot_t       cells [TABLE_DEPTH];
  slot_t       head_d;
  logic        push;
  event_t      push_ev;
  logic        head_hit, head_free, drop_link;
  logic [31:0] age;
  logic        shift;
  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  slot_t       wr_data;
  logic        in_acc;
  logic        emit_load;
  logic        emit_last;

  assign in_acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign shift       = (state_q == StScan);

  // cell chain: each cell takes its upper neighbor, the last takes the updated head
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    slot_t nb;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nb = head_d;
    end else begin : g_mid
      assign nb = cells[g+1];
    end
    crtb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .shift_in_i (nb),
      .wr_en_i    (wr_en && (wr_idx == IdxW'(g))),
      .wr_data_i  (wr_data),
      .slot_o     (cells[g])
    );
  end

  // update the slot at the head of the chain
  always_comb begin
    head_d    = cells[0];
    push      = 1'b0;
    push_ev   = '0;
    head_hit  = 1'b0;
    head_free = 1'b0;
    drop_link = 1'b0;
    age       = now_q - cells[0].sent;
    case (req_q)
      ReqTrack: begin
        head_hit  = cells[0].valid && (cells[0].id == id_q);
        head_free = !cells[0].valid;
      end
      ReqAck: begin
        if (cells[0].valid && (cells[0].id == id_q) && !hit_q) begin
          head_d.valid = 1'b0;
          push    = 1'b1;
          push_ev = '{ev: EvAcked, id: cells[0].id, kind: cells[0].kind,
                      att: cells[0].retries};
        end
      end
      ReqTick: begin
        if (cells[0].valid && ((age >> cells[0].retries) != 32'd0)) begin
          push = 1'b1;
          if (cells[0].retries < retry_limit_q) begin
            head_d.retries = cells[0].retries + 4'd1;
            head_d.sent    = now_q;
            push_ev = '{ev: EvResend, id: cells[0].id, kind: cells[0].kind,
                        att: cells[0].retries + 4'd1};
          end else begin
            head_d.valid = 1'b0;
            drop_link    = 1'b1;
            push_ev = '{ev: EvDropped, id: cells[0].id, kind: cells[0].kind,
                        att: cells[0].retries};
          end
        end
      end
      ReqFlush: begin
        if (cells[0].valid) begin
          head_d.valid = 1'b0;
          push    = 1'b1;
          push_ev = '{ev: EvResend, id: cells[0].id, kind: cells[0].kind,
                      att: cells[0].retries};
        end
      end
      default: begin
      end
    endcase
  end

  // track write after the full rotation
  always_comb begin
    wr_en   = (state_q == StFin) && (req_q == ReqTrack) && (hit_q || free_q);
    wr_idx  = hit_q ? hit_idx_q : free_idx_q;
    wr_data = '{valid: 1'b1, id: id_q, kind: kind_q, retries: 4'd0, sent: now_q};
  end

  assign emit_load = (state_q == StEmit) && (!res_valid_q || res_o.ready);
  assign emit_last = ({1'b0, rd_q} == ResCntW'(cnt_q - ResCntW'(1)));

  // sequencer, status registers, event queue and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      retry_limit_q <= MaxRetriesRst;
      hb_limit_q    <= HbLimitRst;
      now_q         <= '0;
      hb_age_q      <= HbAgeMax;
      link_q        <= 1'b1;
      req_q         <= ReqTrack;
      id_q          <= '0;
      kind_q        <= '0;
      k_q           <= '0;
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      hit_idx_q     <= '0;
      free_idx_q    <= '0;
      cnt_q         <= '0;
      rd_q          <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == CfgMaxRetries) retry_limit_q <= cfg_i.data[3:0];
        if (cfg_i.index == CfgHbLimit)    hb_limit_q    <= cfg_i.data[7:0];
      end
      // drop the shown result once taken, unless the next one replaces it
      if (res_valid_q && res_o.ready && !emit_load) res_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            req_q  <= req_i.req_type;
            id_q   <= req_i.cmd_id;
            kind_q <= req_i.msg_kind;
            k_q    <= '0;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            cnt_q  <= '0;
            rd_q   <= '0;
            if (req_i.req_type == ReqTick) begin
              now_q <= now_q + 32'd1;
              if (hb_age_q != HbAgeMax) hb_age_q <= hb_age_q + 8'd1;
            end
            if (req_i.req_type == ReqHeartbeat)  hb_age_q <= '0;
            if (req_i.req_type == ReqDisconnect) link_q   <= 1'b0;
            if (req_i.req_type == ReqTrack || req_i.req_type == ReqAck ||
                req_i.req_type == ReqTick || req_i.req_type == ReqFlush) begin
              state_q <= StScan;
            end else begin
              state_q <= StFin;
            end
          end
        end
        StScan: begin
          if (head_hit && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= k_q;
          end
          if (req_q == ReqAck && push) hit_q <= 1'b1;
          if (head_free && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= k_q;
          end
          if (drop_link) link_q <= 1'b0;
          if (push && (cnt_q < ResCntW'(MaxResults))) begin
            evq_q[cnt_q[ResIdxW-1:0]] <= push_ev;
            cnt_q <= cnt_q + ResCntW'(1);
          end
          k_q <= k_q + IdxW'(1);
          if (k_q == LastIdx) state_q <= StFin;
        end
        StFin: begin
          if (req_q == ReqFlush) link_q <= 1'b0;
          if (req_q == ReqTrack) begin
            evq_q[0] <= '{ev: (hit_q || free_q) ? EvTracked : EvFull, id: id_q,
                          kind: kind_q, att: 4'd0};
            cnt_q    <= ResCntW'(1);
          end else if (req_q == ReqAck && !hit_q) begin
            evq_q[0] <= '{ev: EvAckUnknown, id: id_q, kind: 16'd0, att: 4'd0};
            cnt_q    <= ResCntW'(1);
          end else if (cnt_q == '0) begin
            evq_q[0] <= '{ev: EvStatus, id: 32'd0, kind: 16'd0, att: 4'd0};
            cnt_q    <= ResCntW'(1);
          end
          state_q <= StEmit;
        end
        StEmit: begin
          if (emit_load) begin
            res_valid_q   <= 1'b1;
            res_ev_q      <= evq_q[rd_q];
            res_healthy_q <= link_q && (hb_age_q < hb_limit_q);
            res_link_q    <= link_q;
            res_last_q    <= emit_last;
            rd_q          <= rd_q + ResIdxW'(1);
            if (emit_last) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.event_res  = res_ev_q.ev;
  assign res_o.out_cmd_id = res_ev_q.id;
  assign res_o.out_kind   = res_ev_q.kind;
  assign res_o.attempt    = res_ev_q.att;
  assign res_o.healthy    = res_healthy_q;
  assign res_o.link_is_up = res_link_q;
  assign res_o.last       = res_last_q;

endmodule
